// ----- rtl/hgc_pkg.sv -----
// Shared types, constants and helpers for the hand gesture classifier.
`default_nettype none

package hgc_pkg;

    localparam int TIME_W    = 48;
    localparam int CFG_W     = 16;
    localparam int NUM_LANES = 2;

    localparam logic [CFG_W-1:0] EXPLODE_WINDOW_RST = 16'd850;
    localparam logic [CFG_W-1:0] RESET_HOLD_RST     = 16'd1100;
    localparam logic [CFG_W-1:0] RESET_COOLDOWN_RST = 16'd1800;

    typedef enum logic [2:0] {
        G_NONE    = 3'd0,
        G_POINT   = 3'd1,
        G_GRAB    = 3'd2,
        G_SCALE   = 3'd3,
        G_FIST    = 3'd4,
        G_PALM    = 3'd5,
        G_EXPLODE = 3'd6,
        G_RESET   = 3'd7
    } gesture_t;

    typedef enum logic [1:0] {
        CFG_EXPLODE_WINDOW = 2'd0,
        CFG_RESET_HOLD     = 2'd1,
        CFG_RESET_COOLDOWN = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [CFG_W-1:0] explode_window;
        logic [CFG_W-1:0] reset_hold;
        logic [CFG_W-1:0] reset_cooldown;
    } cfg_t;

    // lowest bit up: right, fist, palm, pinch
    typedef struct packed {
        logic pinch;
        logic palm;
        logic fist;
        logic right;
    } hand_t;

    typedef struct packed {
        logic              active;
        logic              fist;
        logic              palm;
        logic              pinch;
        logic              explode;
        logic [TIME_W-1:0] slot_out;
    } lane_res_t;

    function automatic logic signed [TIME_W:0] elapsed(
        input logic [TIME_W-1:0] now,
        input logic [TIME_W-1:0] then_t
    );
        return $signed({1'b0, now}) - $signed({1'b0, then_t});
    endfunction

    function automatic logic signed [TIME_W:0] widen_cfg(input logic [CFG_W-1:0] v);
        return $signed({{(TIME_W+1-CFG_W){1'b0}}, v});
    endfunction

endpackage

`default_nettype wire

// ----- rtl/hgc_lane.sv -----
// Per-hand lane: fist slot tracking and explode detection for one hand.
`default_nettype none

module hgc_lane import hgc_pkg::*; (
    input  wire logic              active,
    input  wire hand_t             hand,
    input  wire logic [TIME_W-1:0] time_ms,
    input  wire logic [TIME_W-1:0] since,
    input  wire logic [CFG_W-1:0]  explode_window,
    output lane_res_t              res
);

    logic signed [TIME_W:0] dt;
    logic                   since_set;

    assign dt        = elapsed(time_ms, since);
    assign since_set = (since != '0);

    always_comb begin
        res.active  = active;
        res.fist    = active & hand.fist;
        res.palm    = active & hand.palm;
        res.pinch   = active & hand.pinch;
        res.explode = active & ~hand.fist & hand.palm & since_set &
                      (dt < widen_cfg(explode_window));
        if (!active) begin
            res.slot_out = since;
        end else if (hand.fist) begin
            res.slot_out = since_set ? since : time_ms;
        end else begin
            res.slot_out = '0;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/hgc_merge.sv -----
// Merge stage: gesture priority, hold and cooldown tracking, state and output register.
`default_nettype none

module hgc_merge import hgc_pkg::*; (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             accept,
    input  wire logic [TIME_W-1:0]                time_ms,
    input  wire logic [NUM_LANES-1:0]             lane_right,
    input  wire lane_res_t [NUM_LANES-1:0]        lanes,
    input  wire cfg_t                             cfg,
    input  wire logic                             m_tready,
    output logic [NUM_LANES-1:0][TIME_W-1:0]      fist_slot,
    output logic                                  m_tvalid,
    output gesture_t                              gesture,
    output logic                                  started,
    output logic                                  ended
);

    logic [NUM_LANES-1:0][TIME_W-1:0] fist_slot_reg, fist_slot_next;
    logic [TIME_W-1:0]                pps_reg, pps_next;
    logic [TIME_W-1:0]                lrt_reg, lrt_next;
    gesture_t                         prev_reg;
    gesture_t                         g;
    logic                             m_valid_reg, m_valid_next;
    gesture_t                         gesture_reg;
    logic                             started_reg, ended_reg;

    logic [1:0] pinches, fists, palms;
    logic       explode, both_palms, hold_ok, cool_ok;

    assign fist_slot = fist_slot_reg;
    assign m_tvalid  = m_valid_reg;
    assign gesture   = gesture_reg;
    assign started   = started_reg;
    assign ended     = ended_reg;

    always_comb begin
        pinches = {1'b0, lanes[0].pinch} + {1'b0, lanes[1].pinch};
        fists   = {1'b0, lanes[0].fist}  + {1'b0, lanes[1].fist};
        palms   = {1'b0, lanes[0].palm}  + {1'b0, lanes[1].palm};
        explode = lanes[0].explode | lanes[1].explode;
        both_palms = lanes[1].active & lanes[0].palm & lanes[1].palm;
        hold_ok = (pps_reg != '0) &&
                  (elapsed(time_ms, pps_reg) > widen_cfg(cfg.reset_hold));
        cool_ok = elapsed(time_ms, lrt_reg) > widen_cfg(cfg.reset_cooldown);

        for (int s = 0; s < NUM_LANES; s++) begin
            if (lanes[1].active && (lane_right[1] == s[0])) begin
                fist_slot_next[s] = lanes[1].slot_out;
            end else if (lanes[0].active && (lane_right[0] == s[0])) begin
                fist_slot_next[s] = lanes[0].slot_out;
            end else begin
                fist_slot_next[s] = fist_slot_reg[s];
            end
        end

        pps_next = pps_reg;
        lrt_next = lrt_reg;
        g        = G_NONE;
        if (explode) begin
            g = G_EXPLODE;
        end else begin
            if (both_palms) begin
                pps_next = (pps_reg == '0) ? time_ms : pps_reg;
            end else begin
                pps_next = '0;
            end
            priority if (both_palms && hold_ok && cool_ok) begin
                lrt_next = time_ms;
                g        = G_RESET;
            end else if (pinches >= 2'd2) begin
                g = G_SCALE;
            end else if (pinches == 2'd1) begin
                g = G_GRAB;
            end else if (fists != 2'd0) begin
                g = G_FIST;
            end else if (palms != 2'd0) begin
                g = G_PALM;
            end else if (lanes[0].active) begin
                g = G_POINT;
            end else begin
                g = G_NONE;
            end
        end

        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fist_slot_reg <= '0;
            pps_reg       <= '0;
            lrt_reg       <= '0;
            prev_reg      <= G_NONE;
            m_valid_reg   <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (accept) begin
                fist_slot_reg <= fist_slot_next;
                pps_reg       <= pps_next;
                lrt_reg       <= lrt_next;
                prev_reg      <= g;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            gesture_reg <= g;
            started_reg <= (g != prev_reg) || (g == G_EXPLODE) || (g == G_RESET);
            ended_reg   <= (prev_reg != G_NONE) && (g != prev_reg);
        end
    end

endmodule

`default_nettype wire

// ----- rtl/hand_gesture_classifier.sv -----
// Top level of the hand gesture classifier: stream ports, register port, lanes and merge.
//
//  channel   | direction | payload
//  s_*       | in        | one frame's hand summary per item
//  m_*       | out       | one gesture result per item
//  APB       | in/out    | explode window, reset hold, reset cooldown
//
// One item per cycle while s_tready is high; results appear the cycle after accept.
// The fist slots and hold/reset times update in the cycle an item is taken.
// s_tready drops only while a result waits and m_tready is low.
// Reset clears all tracking state and loads the default register values.
`default_nettype none

module hand_gesture_classifier import hgc_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // time_ms[47:0], hand_num[49:48], hand0 right/fist/palm/pinch[53:50],
    // hand1 right/fist/palm/pinch[57:54], zero[63:58]
    input  wire logic [63:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // gesture[2:0], started[3], ended[4], zero[7:5]
    output logic [7:0]       m_tdata,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    cfg_t                             cfg_reg;
    logic                             accept;
    logic                             cfg_wr;
    cfg_idx_t                         cfg_idx;
    logic [TIME_W-1:0]                time_ms;
    logic [1:0]                       hand_num;
    hand_t [NUM_LANES-1:0]            hands;
    logic [NUM_LANES-1:0]             lane_active;
    logic [NUM_LANES-1:0]             lane_right;
    logic [NUM_LANES-1:0][TIME_W-1:0] lane_since;
    logic [NUM_LANES-1:0][TIME_W-1:0] fist_slot;
    lane_res_t [NUM_LANES-1:0]        lanes;
    gesture_t                         gesture;
    logic                             started, ended;

    assign time_ms    = s_tdata[47:0];
    assign hand_num   = s_tdata[49:48];
    assign hands[0]   = hand_t'(s_tdata[53:50]);
    assign hands[1]   = hand_t'(s_tdata[57:54]);

    assign lane_active[0] = (hand_num != 2'd0);
    assign lane_active[1] = hand_num[1];
    assign lane_right[0]  = hands[0].right;
    assign lane_right[1]  = hands[1].right;

    // hand 1 sees the slot as hand 0 left it when both share a side
    assign lane_since[0] = fist_slot[hands[0].right];
    assign lane_since[1] = (lane_active[0] && (hands[0].right == hands[1].right)) ?
                           lanes[0].slot_out : fist_slot[hands[1].right];

    generate
        for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
            hgc_lane u_lane (
                .active         (lane_active[i]),
                .hand           (hands[i]),
                .time_ms        (time_ms),
                .since          (lane_since[i]),
                .explode_window (cfg_reg.explode_window),
                .res            (lanes[i])
            );
        end
    endgenerate

    assign s_tready = ~m_tvalid | m_tready;
    assign accept   = s_tvalid & s_tready;

    hgc_merge u_merge (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .time_ms    (time_ms),
        .lane_right (lane_right),
        .lanes      (lanes),
        .cfg        (cfg_reg),
        .m_tready   (m_tready),
        .fist_slot  (fist_slot),
        .m_tvalid   (m_tvalid),
        .gesture    (gesture),
        .started    (started),
        .ended      (ended)
    );

    assign m_tdata = {3'b000, ended, started, gesture};

    assign pready  = 1'b1;
    assign cfg_idx = cfg_idx_t'(paddr[3:2]);
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_comb begin
        unique case (cfg_idx)
            CFG_EXPLODE_WINDOW: prdata = {16'd0, cfg_reg.explode_window};
            CFG_RESET_HOLD:     prdata = {16'd0, cfg_reg.reset_hold};
            CFG_RESET_COOLDOWN: prdata = {16'd0, cfg_reg.reset_cooldown};
            default:            prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.explode_window <= EXPLODE_WINDOW_RST;
            cfg_reg.reset_hold     <= RESET_HOLD_RST;
            cfg_reg.reset_cooldown <= RESET_COOLDOWN_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                CFG_EXPLODE_WINDOW: cfg_reg.explode_window <= pwdata[CFG_W-1:0];
                CFG_RESET_HOLD:     cfg_reg.reset_hold     <= pwdata[CFG_W-1:0];
                CFG_RESET_COOLDOWN: cfg_reg.reset_cooldown <= pwdata[CFG_W-1:0];
                default:            cfg_reg <= cfg_reg;
            endcase
        end
    end

endmodule

`default_nettype wire
